### hw/rtl/gspc_pkg.sv
package gspc_pkg;

	localparam int SAMPLE_BITS = 12;
	localparam int FRAC_BITS   = 16;
	localparam int CFG_W       = 16;
	localparam int FUNC_W      = 2;
	localparam int PPM_W       = 32;
	localparam int STAT_W      = 2;
	localparam int ADDR_W      = 3;

	// 100 needs seven bits.
	localparam int HUNDRED_W = 7;
	localparam int PROD_W    = CFG_W + SAMPLE_BITS;
	localparam int NUM_W     = PROD_W + HUNDRED_W;
	localparam int DEN_W     = SAMPLE_BITS + CFG_W;
	localparam int DIVD_W    = NUM_W + FRAC_BITS;
	localparam int POS_W     = $clog2(DIVD_W);

	localparam int MQ        = 30;
	localparam int MANT_W    = MQ + 1;
	localparam int LOGQ      = 16;
	localparam int LOG_INT_W = 7;
	localparam int LOG_W     = LOG_INT_W + LOGQ;
	localparam int INV_W     = 19;
	localparam int C_W       = 22;
	localparam int MUL_W     = LOG_W + INV_W;
	localparam int G_W       = MUL_W - LOGQ + 1;
	localparam int SHIFT_W   = 5;

	localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = '1;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK       = 2'd0,
		STAT_SAT      = 2'd1,
		STAT_RAW_ZERO = 2'd2
	} status_t;

	typedef enum logic {
		REG_RO = 1'b0,
		REG_RL = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_DIV,
		BK_NORM,
		BK_LOG,
		BK_MUL,
		BK_GAIN,
		BK_EXP,
		BK_OUT
	} bk_state_t;

	typedef struct packed {
		logic [CFG_W-1:0] ro;
		logic [CFG_W-1:0] rl;
	} cfg_t;

	typedef struct packed {
		logic              raw_zero;
		logic [FUNC_W-1:0] sel;
		logic [PROD_W-1:0] prod;
		logic [DEN_W-1:0]  den;
	} fq_entry_t;

	typedef logic [LOGQ-1:0][MANT_W-1:0] root_arr_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] res;
		logic [63:0] bitv;
		logic [63:0] rem;
		res  = '0;
		bitv = 64'd1 << 62;
		rem  = v;
		for (int i = 0; i < 32; i++) begin
			if (bitv > rem) begin
				bitv = bitv >> 2;
			end
		end
		for (int i = 0; i < 32; i++) begin
			if (bitv != 0) begin
				if (rem >= res + bitv) begin
					rem = rem - (res + bitv);
					res = (res >> 1) + bitv;
				end else begin
					res = res >> 1;
				end
				bitv = bitv >> 2;
			end
		end
		return res;
	endfunction

	// Successive square roots of two in Q1.30, finest last.
	function automatic root_arr_t root_table();
		root_arr_t   tab;
		logic [63:0] r;
		r = isqrt64(64'd1 << 61);
		for (int i = 0; i < LOGQ; i++) begin
			tab[i] = r[MANT_W-1:0];
			r = isqrt64(r << MQ);
		end
		return tab;
	endfunction

	localparam root_arr_t ROOTS = root_table();

	function automatic logic signed [INV_W-1:0] curve_inv(input logic [FUNC_W-1:0] sel);
		logic signed [INV_W-1:0] v;
		unique case (sel)
			2'd0:    v = -19'sd139438;
			2'd1:    v = -19'sd192753;
			default: v = -19'sd148945;
		endcase
		return v;
	endfunction

	function automatic logic signed [C_W-1:0] curve_c(input logic [FUNC_W-1:0] sel);
		logic signed [C_W-1:0] v;
		unique case (sel)
			2'd0:    v = 22'sd1033408;
			2'd1:    v = 22'sd1397159;
			2'd2:    v = 22'sd1198372;
			default: v = 22'sd1173633;
		endcase
		return v;
	endfunction

endpackage

### hw/rtl/gspc_cfg.sv
module gspc_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [gspc_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	output gspc_pkg::cfg_t             cfg
);

	logic [gspc_pkg::CFG_W-1:0] ro_q;
	logic [gspc_pkg::CFG_W-1:0] rl_q;
	logic                       wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	// Registers sit on word boundaries; the low address bits are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ro_q <= 16'd100;
			rl_q <= 16'd50;
		end else if (wr_en) begin
			unique case (gspc_pkg::reg_idx_t'(paddr[2]))
				gspc_pkg::REG_RO: ro_q <= pwdata[gspc_pkg::CFG_W-1:0];
				gspc_pkg::REG_RL: rl_q <= pwdata[gspc_pkg::CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (gspc_pkg::reg_idx_t'(paddr[2]))
			gspc_pkg::REG_RO: prdata = {16'd0, ro_q};
			gspc_pkg::REG_RL: prdata = {16'd0, rl_q};
			default:          prdata = '0;
		endcase
	end

	assign cfg.ro = ro_q;
	assign cfg.rl = rl_q;

endmodule

### hw/rtl/gspc_front.sv
module gspc_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  gspc_pkg::cfg_t                  cfg,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [gspc_pkg::SAMPLE_BITS-1:0] raw,
	input  logic [gspc_pkg::FUNC_W-1:0]     sel,
	output logic                            push,
	input  logic                            q_full,
	output gspc_pkg::fq_entry_t             entry
);

	logic                       valid_s1;
	gspc_pkg::fq_entry_t        entry_s1;
	logic [gspc_pkg::CFG_W-1:0] ro_eff;

	assign ro_eff   = (cfg.ro == '0) ? gspc_pkg::CFG_W'(1) : cfg.ro;
	assign push     = valid_s1 && !q_full;
	assign in_ready = !valid_s1 || !q_full;
	assign entry    = entry_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Split the ratio into numerator and denominator products here, so the
	// back end only has to scale by 100 and divide.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			entry_s1.raw_zero <= (raw == '0);
			entry_s1.sel      <= sel;
			entry_s1.prod     <= cfg.rl * (gspc_pkg::FULL_SCALE - raw);
			entry_s1.den      <= raw * ro_eff;
		end
	end

endmodule

### hw/rtl/gspc_queue.sv
module gspc_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  gspc_pkg::fq_entry_t wdata,
	output logic                full,
	input  logic                pop,
	output logic                empty,
	output gspc_pkg::fq_entry_t rdata
);

	gspc_pkg::fq_entry_t slot_q [2];
	logic                wr_ptr_q;
	logic                rd_ptr_q;
	logic [1:0]          cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign rdata = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			if (push && !pop)      cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= wdata;
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) !(push && full))
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) !(pop && empty))
		else $error("queue read while empty");
	a_count_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd1) |-> (wr_ptr_q != rd_ptr_q))
		else $error("queue pointers disagree with count");
`endif

endmodule

### hw/rtl/gspc_back.sv
module gspc_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_empty,
	input  gspc_pkg::fq_entry_t         head,
	output logic                        pop,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [gspc_pkg::PPM_W-1:0]  ppm,
	output logic [gspc_pkg::STAT_W-1:0] status
);

	localparam int DW = gspc_pkg::DIVD_W;
	localparam int MW = gspc_pkg::MANT_W;

	gspc_pkg::bk_state_t state_q, state_d;

	logic [DW-1:0]                 divd_q;
	logic [gspc_pkg::DEN_W-1:0]    den_q;
	logic [gspc_pkg::DEN_W-1:0]    rem_q;
	logic [gspc_pkg::POS_W-1:0]    cnt_q;
	logic                          found_q;
	logic [gspc_pkg::POS_W-1:0]    pos_q;
	logic [MW-1:0]                 mant_q;
	logic [gspc_pkg::LOGQ-1:0]     frac_q;
	logic [gspc_pkg::FUNC_W-1:0]   sel_q;
	logic signed [gspc_pkg::MUL_W-1:0] mul_q;
	logic [gspc_pkg::G_W-1:0]      g_q;
	logic [gspc_pkg::PPM_W-1:0]    res_q;
	gspc_pkg::status_t             stat_q;

	logic                          out_valid_q;
	logic [gspc_pkg::PPM_W-1:0]    ppm_q;
	gspc_pkg::status_t             status_q;

	logic [gspc_pkg::DEN_W:0]      rem_trial;
	logic                          qbit;
	logic [gspc_pkg::NUM_W-1:0]    num_full;
	logic [DW-1:0]                 norm_val;
	logic [2*MW-1:0]               sq;
	logic [2*MW-1:0]               exp_prod;
	logic signed [gspc_pkg::LOG_INT_W-1:0] log_int;
	logic signed [gspc_pkg::LOG_W-1:0]     log_val;
	logic signed [gspc_pkg::G_W-1:0]       g_val;
	logic [2*MW-1:0]               wide;
	logic                          out_load;
	logic [gspc_pkg::POS_W-1:0]    exp_bit;

	assign pop      = (state_q == gspc_pkg::BK_IDLE) && !q_empty;
	assign out_load = (state_q == gspc_pkg::BK_OUT) && (!out_valid_q || out_ready);

	// 100 * prod as a sum of shifts.
	assign num_full = (gspc_pkg::NUM_W'(head.prod) << 6) + (gspc_pkg::NUM_W'(head.prod) << 5)
		+ (gspc_pkg::NUM_W'(head.prod) << 2);

	assign rem_trial = {rem_q, divd_q[DW-1]};
	assign qbit      = (rem_trial >= {1'b0, den_q});

	always_comb begin
		if (pos_q >= gspc_pkg::POS_W'(gspc_pkg::MQ)) begin
			norm_val = divd_q >> (pos_q - gspc_pkg::POS_W'(gspc_pkg::MQ));
		end else begin
			norm_val = divd_q << (gspc_pkg::POS_W'(gspc_pkg::MQ) - pos_q);
		end
	end

	assign sq       = mant_q * mant_q;
	assign exp_bit  = gspc_pkg::POS_W'(gspc_pkg::LOGQ - 1) - cnt_q;
	assign exp_prod = mant_q * gspc_pkg::ROOTS[cnt_q[$clog2(gspc_pkg::LOGQ)-1:0]];
	assign log_int  = $signed({1'b0, pos_q}) - gspc_pkg::LOG_INT_W'(gspc_pkg::FRAC_BITS);
	assign log_val  = {log_int, frac_q};
	assign g_val    = $signed({mul_q[gspc_pkg::MUL_W-1], mul_q[gspc_pkg::MUL_W-1:gspc_pkg::LOGQ]})
		+ gspc_pkg::G_W'(gspc_pkg::curve_c(sel_q));
	assign wide     = {{MW{1'b0}}, mant_q} << g_q[gspc_pkg::LOGQ +: gspc_pkg::SHIFT_W];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			gspc_pkg::BK_IDLE: if (!q_empty) begin
				state_d = head.raw_zero ? gspc_pkg::BK_OUT : gspc_pkg::BK_DIV;
			end
			gspc_pkg::BK_DIV: if (cnt_q == gspc_pkg::POS_W'(DW - 1)) begin
				state_d = (found_q || qbit) ? gspc_pkg::BK_NORM : gspc_pkg::BK_OUT;
			end
			gspc_pkg::BK_NORM: state_d = gspc_pkg::BK_LOG;
			gspc_pkg::BK_LOG: if (cnt_q == gspc_pkg::POS_W'(gspc_pkg::LOGQ - 1)) begin
				state_d = gspc_pkg::BK_MUL;
			end
			gspc_pkg::BK_MUL: state_d = gspc_pkg::BK_GAIN;
			gspc_pkg::BK_GAIN: begin
				if (g_val[gspc_pkg::G_W-1] || (g_val[gspc_pkg::G_W-2:gspc_pkg::LOGQ+5] != '0)) begin
					state_d = gspc_pkg::BK_OUT;
				end else begin
					state_d = gspc_pkg::BK_EXP;
				end
			end
			gspc_pkg::BK_EXP: if (cnt_q == gspc_pkg::POS_W'(gspc_pkg::LOGQ)) begin
				state_d = gspc_pkg::BK_OUT;
			end
			gspc_pkg::BK_OUT: if (!out_valid_q || out_ready) begin
				state_d = gspc_pkg::BK_IDLE;
			end
			default: state_d = gspc_pkg::BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gspc_pkg::BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			gspc_pkg::BK_IDLE: begin
				divd_q  <= DW'(num_full) << gspc_pkg::FRAC_BITS;
				den_q   <= head.den;
				rem_q   <= '0;
				cnt_q   <= '0;
				found_q <= 1'b0;
				sel_q   <= head.sel;
				res_q   <= '0;
				stat_q  <= gspc_pkg::STAT_RAW_ZERO;
			end
			gspc_pkg::BK_DIV: begin
				rem_q  <= qbit ? gspc_pkg::DEN_W'(rem_trial - {1'b0, den_q})
					: rem_trial[gspc_pkg::DEN_W-1:0];
				divd_q <= {divd_q[DW-2:0], qbit};
				cnt_q  <= cnt_q + 1'b1;
				if (qbit && !found_q) begin
					found_q <= 1'b1;
					pos_q   <= gspc_pkg::POS_W'(DW - 1) - cnt_q;
				end
				// A zero quotient saturates.
				res_q  <= '1;
				stat_q <= gspc_pkg::STAT_SAT;
			end
			gspc_pkg::BK_NORM: begin
				mant_q <= norm_val[MW-1:0];
				cnt_q  <= '0;
			end
			gspc_pkg::BK_LOG: begin
				// Each squaring yields one fraction bit of the logarithm.
				cnt_q  <= cnt_q + 1'b1;
				frac_q <= {frac_q[gspc_pkg::LOGQ-2:0], sq[2*MW-1]};
				mant_q <= sq[2*MW-1] ? sq[2*MW-1:gspc_pkg::MQ+1] : sq[2*MW-2:gspc_pkg::MQ];
			end
			gspc_pkg::BK_MUL: begin
				mul_q <= log_val * gspc_pkg::curve_inv(sel_q);
			end
			gspc_pkg::BK_GAIN: begin
				g_q    <= g_val;
				cnt_q  <= '0;
				mant_q <= MW'(1) << gspc_pkg::MQ;
				if (g_val[gspc_pkg::G_W-1]) begin
					res_q  <= '0;
					stat_q <= gspc_pkg::STAT_OK;
				end else begin
					res_q  <= '1;
					stat_q <= gspc_pkg::STAT_SAT;
				end
			end
			gspc_pkg::BK_EXP: begin
				if (cnt_q == gspc_pkg::POS_W'(gspc_pkg::LOGQ)) begin
					res_q  <= wide[2*MW-1:gspc_pkg::MQ];
					stat_q <= gspc_pkg::STAT_OK;
				end else begin
					cnt_q <= cnt_q + 1'b1;
					if (g_q[exp_bit[$clog2(gspc_pkg::LOGQ)-1:0]]) begin
						mant_q <= exp_prod[gspc_pkg::MQ +: MW];
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			ppm_q    <= res_q;
			status_q <= stat_q;
		end
	end

	assign out_valid = out_valid_q;
	assign ppm       = ppm_q;
	assign status    = status_q;

`ifndef NO_ASSERTIONS
	a_raw_zero_ppm: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q == gspc_pkg::STAT_RAW_ZERO) |-> (ppm_q == '0))
		else $error("raw-zero item carries a nonzero result");
	a_sat_ppm: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q == gspc_pkg::STAT_SAT) |-> (ppm_q == '1))
		else $error("saturated item not at full scale");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (state_q != gspc_pkg::BK_IDLE))
		else $error("back end stayed idle after taking an item");
`endif

endmodule

### hw/rtl/gas_sensor_ppm_converter.sv
// Gas sensor ppm converter.
// Input channel s_axis: tdata holds raw_sample in bits 11:0, tuser holds func (gas curve:
// 0 LPG, 1 CO, 2 smoke, 3 alcohol). Output channel m_axis: tdata holds ppm_value, tuser
// holds status (0 ok, 1 saturated or ratio zero, 2 raw reading zero).
// The APB port sets Ro (address 0) and RL (address 4) in tenths of a kilo-ohm; write
// them only while no item is in flight.
// A front stage registers the resistance products and hands each item to a two-entry
// queue; the back end divides bit-serially, takes the log2 by 16 squarings,
// scales by the curve, and rebuilds the power of two with 16 root multiplies.
// The back end works on one item at a time and pops the next only from its idle state;
// a zero raw reading goes straight to the output register, skipping the divider and
// the log and power loops.
// The front keeps accepting while the queue has room, so up to three items wait
// behind the one in work. A result waits in the output register while m_axis_tready
// is low; the back end then holds its next result, and the queue fills and drops
// s_axis_tready. Reset empties the queue and pipeline and sets Ro to 100, RL to 50.
module gas_sensor_ppm_converter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // raw_sample[11:0], zero fill
	input  logic [1:0]  s_axis_tuser,  // func[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // ppm_value[31:0]
	output logic [1:0]  m_axis_tuser,  // status[1:0]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	gspc_pkg::cfg_t      cfg;
	gspc_pkg::fq_entry_t push_entry;
	gspc_pkg::fq_entry_t head;
	logic                push;
	logic                q_full;
	logic                q_empty;
	logic                pop;

	gspc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	gspc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.raw      (s_axis_tdata[gspc_pkg::SAMPLE_BITS-1:0]),
		.sel      (s_axis_tuser),
		.push     (push),
		.q_full   (q_full),
		.entry    (push_entry)
	);

	gspc_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_entry),
		.full   (q_full),
		.pop    (pop),
		.empty  (q_empty),
		.rdata  (head)
	);

	gspc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.head      (head),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.ppm       (m_axis_tdata),
		.status    (m_axis_tuser)
	);

endmodule

### verif/ppm_checker.sv
module ppm_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // raw_sample[11:0], zero fill
	input  logic [1:0]  s_axis_tuser,  // func[1:0]
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [31:0] m_axis_tdata,  // ppm_value[31:0]
	input  logic [1:0]  m_axis_tuser,  // status[1:0]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          ppm_pending,
	output int          fail_count
);

	typedef struct {
		logic [31:0]       ppm;
		gspc_pkg::status_t stat;
	} ppm_result_t;

	localparam longint GAS_INV [4] = '{-139438, -192753, -148945, -148945};
	localparam longint GAS_OFS [4] = '{1033408, 1397159, 1198372, 1173633};

	ppm_result_t ppm_due[$];
	logic [15:0] ro_shadow;
	logic [15:0] rl_shadow;

	function automatic longint unsigned sqrt_floor(input longint unsigned v);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b   = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v   = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic ppm_result_t predict_ppm(input logic [11:0] raw, input logic [1:0] gas,
			input logic [15:0] ro_val, input logic [15:0] rl_val);
		ppm_result_t     res;
		longint unsigned num, den, q, r, m, root;
		longint          lg, prod, g, frac;
		int              p, n;
		res.ppm  = '0;
		res.stat = gspc_pkg::STAT_OK;
		if (raw == 0) begin
			res.stat = gspc_pkg::STAT_RAW_ZERO;
			return res;
		end
		num = 64'd100 * rl_val * (64'd4095 - raw);
		den = raw * ((ro_val == 0) ? 64'd1 : 64'(ro_val));
		q   = num / den;
		r   = num % den;
		for (int i = 0; i < 16; i++) begin
			if (q >= (64'd1 << 62)) begin
				q = (64'd1 << 63) - 1;
				break;
			end
			r = r << 1;
			q = q << 1;
			if (r >= den) begin
				r = r - den;
				q = q | 1;
			end
		end
		if (q == 0) begin
			res.ppm  = '1;
			res.stat = gspc_pkg::STAT_SAT;
			return res;
		end
		// Log2: integer part from the leading one, fraction by repeated squaring.
		p = 63;
		while (q[p] == 1'b0) p--;
		m    = (p >= 30) ? (q >> (p - 30)) : (q << (30 - p));
		frac = 0;
		for (int i = 0; i < 16; i++) begin
			m    = (m * m) >> 30;
			frac = frac << 1;
			if (m >= (64'd1 << 31)) begin
				frac = frac | 1;
				m    = m >> 1;
			end
		end
		lg   = longint'(p - 16) * 65536 + frac;
		prod = lg * GAS_INV[gas];
		g    = (prod >= 0) ? prod / 65536 : -((-prod + 65535) / 65536);
		g    = g + GAS_OFS[gas];
		if (g < 0) return res;
		if (g >= (longint'(32) << 16)) begin
			res.ppm  = '1;
			res.stat = gspc_pkg::STAT_SAT;
			return res;
		end
		// Power of two: fraction from a product of successive roots of two.
		n    = int'(g >>> 16);
		m    = 64'd1 << 30;
		root = sqrt_floor(64'd1 << 61);
		for (int i = 15; i >= 0; i--) begin
			if (g[i]) m = (m * root) >> 30;
			root = sqrt_floor(root << 30);
		end
		m = (m << n) >> 30;
		if (m > 64'hFFFF_FFFF) begin
			res.ppm  = '1;
			res.stat = gspc_pkg::STAT_SAT;
		end else begin
			res.ppm = m[31:0];
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		ppm_result_t want;
		if (!arst_n) begin
			ppm_due.delete();
			ro_shadow   <= 16'd100;
			rl_shadow   <= 16'd50;
			ppm_pending <= 0;
			fail_count  <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (gspc_pkg::reg_idx_t'(paddr[2]) == gspc_pkg::REG_RO) ro_shadow <= pwdata[15:0];
				else rl_shadow <= pwdata[15:0];
			end
			if (s_axis_tvalid && s_axis_tready)
				ppm_due.push_back(predict_ppm(s_axis_tdata[11:0], s_axis_tuser,
					ro_shadow, rl_shadow));
			if (m_axis_tvalid && m_axis_tready) begin
				if (ppm_due.size() == 0) begin
					$error("unexpected result item: ppm_value %0d status %0d",
						m_axis_tdata, m_axis_tuser);
					fail_count <= fail_count + 1;
				end else begin
					want = ppm_due.pop_front();
					if (m_axis_tdata !== want.ppm) begin
						$error("ppm_value: expected %0d, got %0d", want.ppm, m_axis_tdata);
						fail_count <= fail_count + 1;
					end
					if (m_axis_tuser !== want.stat) begin
						$error("status: expected %0d, got %0d", want.stat, m_axis_tuser);
						fail_count <= fail_count + 1;
					end
				end
			end
			ppm_pending <= ppm_due.size();
		end
	end

endmodule

### verif/testbench.sv
module testbench;

	localparam int STALL_LIMIT = 20000;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata;  // raw_sample[11:0], zero fill
	logic [1:0]  s_axis_tuser;  // func[1:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;  // ppm_value[31:0]
	logic [1:0]  m_axis_tuser;  // status[1:0]
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int ppm_pending;
	int fail_count;
	int idle_cycles;
	int rdy_hold;
	int rdy_roll;
	bit sender_calm;

	gas_sensor_ppm_converter u_dut (.*);

	ppm_checker u_chk (.*);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Receiver: mostly ready, short stalls, now and then a long one.
	always @(posedge clk) begin
		if (rdy_hold > 0) begin
			rdy_hold <= rdy_hold - 1;
		end else begin
			rdy_roll = $urandom_range(0, 99);
			if (rdy_roll < 60) begin
				m_axis_tready <= 1'b1;
				rdy_hold      <= $urandom_range(0, 40);
			end else if (rdy_roll < 95) begin
				m_axis_tready <= 1'b0;
				rdy_hold      <= $urandom_range(0, 3);
			end else begin
				m_axis_tready <= 1'b0;
				rdy_hold      <= $urandom_range(10, 80);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(psel && penable))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("gas_sensor_ppm_converter test failed");
			$finish;
		end
	end

	task automatic reg_write(input gspc_pkg::reg_idx_t idx, input logic [15:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {16'd0, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_sample(input logic [11:0] raw, input logic [1:0] gas);
		int gap;
		int roll;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {4'd0, raw};
		s_axis_tuser  <= gas;
		do @(negedge clk); while (!s_axis_tready);
		@(posedge clk);
		roll = $urandom_range(0, 99);
		if (sender_calm || roll < 50) gap = 0;
		else if (roll < 95) gap = $urandom_range(1, 4);
		else gap = $urandom_range(10, 80);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Lets every expected result arrive, then some settling time.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		repeat (2) @(posedge clk);
		while (ppm_pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic random_phase(input logic [15:0] ro_val, input logic [15:0] rl_val,
			input int count);
		int          roll;
		logic [11:0] raw;
		reg_write(gspc_pkg::REG_RO, ro_val);
		reg_write(gspc_pkg::REG_RL, rl_val);
		for (int i = 0; i < count; i++) begin
			sender_calm = ((i / 50) % 3 == 2);
			roll = $urandom_range(0, 99);
			if (roll < 4) raw = 12'd0;
			else if (roll < 8) raw = 12'hFFF;
			else if (roll < 14) raw = 12'($urandom_range(1, 8));
			else if (roll < 20) raw = 12'($urandom_range(4087, 4094));
			else raw = 12'($urandom_range(0, 4095));
			send_sample(raw, 2'($urandom_range(0, 3)));
		end
		sender_calm = 1'b0;
		drain();
	endtask

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		m_axis_tready = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		rdy_hold      = 0;
		idle_cycles   = 0;
		sender_calm   = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset values of Ro and RL: every gas at the scale extremes and midscale.
		for (int f = 0; f < 4; f++) begin
			send_sample(12'd0, 2'(f));
			send_sample(12'd1, 2'(f));
			send_sample(12'd2048, 2'(f));
			send_sample(12'd4094, 2'(f));
			send_sample(12'hFFF, 2'(f));
		end
		drain();
		// Zero RL gives a zero ratio; zero Ro counts as one.
		reg_write(gspc_pkg::REG_RL, 16'd0);
		send_sample(12'd1000, 2'd1);
		drain();
		reg_write(gspc_pkg::REG_RO, 16'd0);
		reg_write(gspc_pkg::REG_RL, 16'd65535);
		send_sample(12'd1, 2'd0);
		send_sample(12'd3000, 2'd3);
		drain();

		random_phase(16'd100, 16'd50, 250);
		random_phase(16'd1, 16'd65535, 200);
		random_phase(16'd65535, 16'd1, 200);
		random_phase(16'd65535, 16'd65535, 100);
		random_phase(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)), 150);
		random_phase(16'($urandom_range(1, 400)), 16'($urandom_range(1, 400)), 130);

		repeat (200) @(posedge clk);
		if (fail_count == 0 && ppm_pending == 0) begin
			$display("gas_sensor_ppm_converter test passed");
		end else begin
			$display("gas_sensor_ppm_converter test failed");
		end
		$finish;
	end

endmodule

### sim.f
hw/rtl/gspc_pkg.sv
hw/rtl/gspc_cfg.sv
hw/rtl/gspc_front.sv
hw/rtl/gspc_queue.sv
hw/rtl/gspc_back.sv
hw/rtl/gas_sensor_ppm_converter.sv
verif/ppm_checker.sv
verif/testbench.sv
